>>> rtl/pixel_hsv_color_classifier_defines.svh
// Assertion macros shared by the pixel HSV classifier RTL.
// No dependencies; the including module must provide clk and arst_n.
`ifndef PIXEL_HSV_COLOR_CLASSIFIER_DEFINES_SVH
`define PIXEL_HSV_COLOR_CLASSIFIER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PHCC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("phcc: invariant check failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define PHCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("phcc: sequencing check failed");

`endif

>>> rtl/phcc_pkg.sv
// Package for the pixel HSV classifier: widths, constants, class codes
// and the structs that travel down the pipeline. No dependencies.
`timescale 1ns / 1ps

package phcc_pkg;

	localparam int CH_W   = 5;   // one color channel
	localparam int SUM_W  = 7;   // r+g+b
	localparam int UNIT_W = 9;   // signed sector unit times d
	localparam int PIX_W  = 16;
	localparam int CLS_W  = 3;

	// Hue divider: remainder, divisor (1000*d) and quotient widths.
	localparam int HREM_W = 24;
	localparam int HDEN_W = 15;
	localparam int HQ_W   = 9;
	localparam int HPROD_W = 26;
	localparam int HTURN_W = 25;

	// Saturation divider: 100*d over max.
	localparam int SREM_W = 12;
	localparam int SDEN_W = 5;
	localparam int SQ_W   = 7;

	// Saturation steps run in the last SQ_W of the HQ_W divider stages.
	localparam int SAT_FIRST = HQ_W - SQ_W;

	// Hue scale 57.295 degrees per unit kept as 57295/1000.
	localparam int HUE_NUM  = 57295;
	localparam int HUE_DEN  = 1000;
	localparam int HUE_TURN = 360000;
	localparam int PCT      = 100;
	localparam int SAT_MIN  = 30;

	// Division by three of a sum below 94: (sum * 171) >> 9 is exact.
	localparam int THIRD_MUL   = 171;
	localparam int THIRD_SHIFT = 9;
	localparam int THIRD_W     = 15;

	// Channel thresholds.
	localparam logic [CH_W-1:0] WHITE_MIN = 5'd17;
	localparam logic [CH_W-1:0] BLACK_MAX = 5'd10;
	localparam logic [CH_W-1:0] HIGH_MIN  = 5'd15;
	localparam logic [CH_W-1:0] LOW_MAX   = 5'd15;
	localparam logic [CH_W-1:0] YEL_MIN   = 5'd18;

	// Hue windows in degrees.
	localparam logic [HQ_W-1:0] RED_HUE_HI = 9'd300;
	localparam logic [HQ_W-1:0] RED_HUE_LO = 9'd60;
	localparam logic [HQ_W-1:0] YEL_HUE_LO = 9'd50;
	localparam logic [HQ_W-1:0] YEL_HUE_HI = 9'd80;
	localparam logic [HQ_W-1:0] GRN_HUE_LO = 9'd80;
	localparam logic [HQ_W-1:0] GRN_HUE_HI = 9'd120;
	localparam logic [HQ_W-1:0] BLU_HUE_LO = 9'd180;
	localparam logic [HQ_W-1:0] BLU_HUE_HI = 9'd250;
	localparam logic [HQ_W-1:0] HUE_LIMIT  = 9'd360;
	localparam logic [SQ_W-1:0] SAT_LIMIT  = 7'd100;

	typedef enum logic [CLS_W-1:0] {
		CLS_WHITE  = 3'd0,
		CLS_BLACK  = 3'd1,
		CLS_RED    = 3'd2,
		CLS_YELLOW = 3'd3,
		CLS_GREEN  = 3'd4,
		CLS_BLUE   = 3'd5,
		CLS_OTHER  = 3'd6
	} color_class_t;

	// Per-pixel values that ride alongside the dividers.
	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] v;
		logic            d_zero;
		logic            mx_zero;
		logic            sat_over_30;
	} side_t;

	// Divider state for one pixel.
	typedef struct packed {
		logic [HREM_W-1:0] hue_rem;
		logic [HDEN_W-1:0] hue_den;
		logic [HQ_W-1:0]   hue_q;
		logic [SREM_W-1:0] sat_rem;
		logic [SDEN_W-1:0] sat_den;
		logic [SQ_W-1:0]   sat_q;
		side_t             side;
	} div_t;

endpackage

>>> rtl/phcc_channels.sv
// Stream channel interfaces of the pixel HSV classifier: pixel in, result out.
// Depends on phcc_pkg for field widths.
`timescale 1ns / 1ps

interface phcc_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [phcc_pkg::PIX_W-1:0]  pixel_word;

	modport source (output valid, output pixel_word, input ready);
	modport sink (input valid, input pixel_word, output ready);
endinterface

interface phcc_result_if;
	logic                        valid;
	logic                        ready;
	logic [phcc_pkg::CLS_W-1:0]  color_class;
	logic [phcc_pkg::PIX_W-1:0]  gray_pixel;
	logic [phcc_pkg::HQ_W-1:0]   hue_degrees;
	logic [phcc_pkg::SQ_W-1:0]   saturation_percent;
	logic [phcc_pkg::CH_W-1:0]   value_level;

	modport source (output valid, output color_class, output gray_pixel,
		output hue_degrees, output saturation_percent, output value_level,
		input ready);
	modport sink (input valid, input color_class, input gray_pixel,
		input hue_degrees, input saturation_percent, input value_level,
		output ready);
endinterface

>>> rtl/phcc_front.sv
// Front end: channel unpack, max/min, mean, sector unit and divider setup.
// Three register stages; depends on phcc_pkg and phcc_pixel_if.
`timescale 1ns / 1ps

module phcc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	phcc_pixel_if.sink        pix,
	output logic              valid_out,
	output phcc_pkg::div_t    data_out
);

	// Stage 1: channels, max, min, sum.
	logic                          valid_s1;
	logic [phcc_pkg::CH_W-1:0]     r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [phcc_pkg::SUM_W-1:0]    sum_s1;

	logic [phcc_pkg::CH_W-1:0]     r_in, g_in, b_in, mx_rg, mn_rg, mx_in, mn_in;

	assign r_in  = pix.pixel_word[15:11];
	assign g_in  = pix.pixel_word[10:6];
	assign b_in  = pix.pixel_word[4:0];
	assign mx_rg = (g_in > r_in) ? g_in : r_in;
	assign mx_in = (b_in > mx_rg) ? b_in : mx_rg;
	assign mn_rg = (g_in < r_in) ? g_in : r_in;
	assign mn_in = (b_in < mn_rg) ? b_in : mn_rg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1   <= r_in;
			g_s1   <= g_in;
			b_s1   <= b_in;
			mx_s1  <= mx_in;
			mn_s1  <= mn_in;
			sum_s1 <= 7'(r_in) + 7'(g_in) + 7'(b_in);
		end
	end

	// Stage 2: spread d, signed sector unit scaled by d, and the mean.
	logic                            valid_s2;
	logic [phcc_pkg::CH_W-1:0]       r_s2, g_s2, b_s2, mx_s2, d_s2, v_s2;
	logic signed [phcc_pkg::UNIT_W-1:0] units_s2;

	logic [phcc_pkg::CH_W-1:0]          d_c;
	logic signed [phcc_pkg::UNIT_W-1:0] rs, gs, bs, ds, units_c;
	logic [phcc_pkg::THIRD_W-1:0]       third_prod;

	assign d_c = mx_s1 - mn_s1;
	assign rs  = $signed({4'b0, r_s1});
	assign gs  = $signed({4'b0, g_s1});
	assign bs  = $signed({4'b0, b_s1});
	assign ds  = $signed({4'b0, d_c});

	always_comb begin
		if (r_s1 == mx_s1) begin
			units_c = gs - bs;
		end else if (g_s1 == mx_s1) begin
			units_c = (ds <<< 1) + bs - rs;
		end else begin
			units_c = (ds <<< 2) + rs - gs;
		end
	end

	assign third_prod = {8'b0, sum_s1} * phcc_pkg::THIRD_W'(phcc_pkg::THIRD_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2     <= r_s1;
			g_s2     <= g_s1;
			b_s2     <= b_s1;
			mx_s2    <= mx_s1;
			d_s2     <= d_c;
			v_s2     <= third_prod[phcc_pkg::THIRD_SHIFT +: phcc_pkg::CH_W];
			units_s2 <= units_c;
		end
	end

	// Stage 3: dividend and divisor of both quotients.
	logic signed [phcc_pkg::HPROD_W-1:0] hue_prod, hue_sum;
	logic [phcc_pkg::HTURN_W-1:0]        turn_d;
	logic [phcc_pkg::SREM_W-1:0]         d_pct, mx_min;
	phcc_pkg::div_t                      setup;

	assign hue_prod = $signed(phcc_pkg::HPROD_W'(phcc_pkg::HUE_NUM))
		* $signed({{(phcc_pkg::HPROD_W-phcc_pkg::UNIT_W){units_s2[phcc_pkg::UNIT_W-1]}},
			units_s2});
	assign turn_d  = phcc_pkg::HTURN_W'(d_s2) * phcc_pkg::HTURN_W'(phcc_pkg::HUE_TURN);
	// A negative unit wraps by a full turn.
	assign hue_sum = hue_prod + (units_s2[phcc_pkg::UNIT_W-1]
		? $signed({1'b0, turn_d}) : {phcc_pkg::HPROD_W{1'b0}});
	assign d_pct   = phcc_pkg::SREM_W'(d_s2) * phcc_pkg::SREM_W'(phcc_pkg::PCT);
	assign mx_min  = phcc_pkg::SREM_W'(mx_s2) * phcc_pkg::SREM_W'(phcc_pkg::SAT_MIN);

	always_comb begin
		setup.hue_rem          = hue_sum[phcc_pkg::HREM_W-1:0];
		setup.hue_den          = phcc_pkg::HDEN_W'(d_s2)
			* phcc_pkg::HDEN_W'(phcc_pkg::HUE_DEN);
		setup.hue_q            = '0;
		setup.sat_rem          = d_pct;
		setup.sat_den          = mx_s2;
		setup.sat_q            = '0;
		setup.side.r           = r_s2;
		setup.side.g           = g_s2;
		setup.side.b           = b_s2;
		setup.side.v           = v_s2;
		setup.side.d_zero      = (d_s2 == '0);
		setup.side.mx_zero     = (mx_s2 == '0);
		setup.side.sat_over_30 = (d_pct > mx_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (adv) begin
			valid_out <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_out <= setup;
		end
	end

endmodule

>>> rtl/phcc_div_stage.sv
// One restoring-division step for hue and, optionally, saturation.
// One register stage; depends on phcc_pkg.
`timescale 1ns / 1ps

module phcc_div_stage #(
	parameter int SHIFT  = 0,
	parameter bit SAT_EN = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            valid_in,
	input  phcc_pkg::div_t  data_in,
	output logic            valid_s1,
	output phcc_pkg::div_t  data_s1
);

	logic [phcc_pkg::HREM_W-1:0] hue_trial;
	logic [phcc_pkg::SREM_W-1:0] sat_rem_nxt;
	logic [phcc_pkg::SQ_W-1:0]   sat_q_nxt;
	phcc_pkg::div_t              nxt;

	assign hue_trial = {{(phcc_pkg::HREM_W-phcc_pkg::HDEN_W){1'b0}}, data_in.hue_den} << SHIFT;

	generate
		if (SAT_EN) begin : g_sat
			logic [phcc_pkg::SREM_W-1:0] sat_trial;
			assign sat_trial =
				{{(phcc_pkg::SREM_W-phcc_pkg::SDEN_W){1'b0}}, data_in.sat_den} << SHIFT;
			always_comb begin
				sat_rem_nxt = data_in.sat_rem;
				sat_q_nxt   = data_in.sat_q;
				if (data_in.sat_rem >= sat_trial) begin
					sat_rem_nxt      = data_in.sat_rem - sat_trial;
					sat_q_nxt[SHIFT] = 1'b1;
				end
			end
		end else begin : g_nosat
			assign sat_rem_nxt = data_in.sat_rem;
			assign sat_q_nxt   = data_in.sat_q;
		end
	endgenerate

	always_comb begin
		nxt = data_in;
		if (data_in.hue_rem >= hue_trial) begin
			nxt.hue_rem      = data_in.hue_rem - hue_trial;
			nxt.hue_q[SHIFT] = 1'b1;
		end
		nxt.sat_rem = sat_rem_nxt;
		nxt.sat_q   = sat_q_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

endmodule

>>> rtl/phcc_classify.sv
// Output stage: zero-spread fixups, gray pixel and color class decision.
// Depends on phcc_pkg, phcc_result_if and the assertion macro header.
`timescale 1ns / 1ps
`include "pixel_hsv_color_classifier_defines.svh"

module phcc_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            valid_in,
	input  phcc_pkg::div_t  data_in,
	phcc_result_if.source   res
);

	logic                         valid_s12;
	logic [phcc_pkg::CLS_W-1:0]   cls_s12;
	logic [phcc_pkg::PIX_W-1:0]   gray_s12;
	logic [phcc_pkg::HQ_W-1:0]    hue_s12;
	logic [phcc_pkg::SQ_W-1:0]    sat_s12;
	logic [phcc_pkg::CH_W-1:0]    v_s12;

	logic [phcc_pkg::CH_W-1:0]    r, g, b, v;
	logic [phcc_pkg::HQ_W-1:0]    hue;
	logic [phcc_pkg::SQ_W-1:0]    sat;
	phcc_pkg::color_class_t       cls;

	assign r   = data_in.side.r;
	assign g   = data_in.side.g;
	assign b   = data_in.side.b;
	assign v   = data_in.side.v;
	// Equal channels have no hue; a zero max has no saturation.
	assign hue = data_in.side.d_zero ? '0 : data_in.hue_q;
	assign sat = data_in.side.mx_zero ? '0 : data_in.sat_q;

	// First matching class wins.
	always_comb begin
		if (r > phcc_pkg::WHITE_MIN && g > phcc_pkg::WHITE_MIN
				&& b > phcc_pkg::WHITE_MIN && v > phcc_pkg::WHITE_MIN) begin
			cls = phcc_pkg::CLS_WHITE;
		end else if (r < phcc_pkg::BLACK_MAX && g < phcc_pkg::BLACK_MAX
				&& b < phcc_pkg::BLACK_MAX && v < phcc_pkg::BLACK_MAX) begin
			cls = phcc_pkg::CLS_BLACK;
		end else if (r > phcc_pkg::HIGH_MIN && g < phcc_pkg::LOW_MAX && b < phcc_pkg::LOW_MAX
				&& (hue > phcc_pkg::RED_HUE_HI || hue < phcc_pkg::RED_HUE_LO)) begin
			cls = phcc_pkg::CLS_RED;
		end else if (r > phcc_pkg::YEL_MIN && g > phcc_pkg::YEL_MIN && b < phcc_pkg::LOW_MAX
				&& v > phcc_pkg::HIGH_MIN
				&& hue > phcc_pkg::YEL_HUE_LO && hue < phcc_pkg::YEL_HUE_HI) begin
			cls = phcc_pkg::CLS_YELLOW;
		end else if (r < phcc_pkg::LOW_MAX && g > phcc_pkg::HIGH_MIN && b < phcc_pkg::LOW_MAX
				&& hue > phcc_pkg::GRN_HUE_LO && hue < phcc_pkg::GRN_HUE_HI) begin
			cls = phcc_pkg::CLS_GREEN;
		end else if (r < b && g < b && hue > phcc_pkg::BLU_HUE_LO
				&& hue < phcc_pkg::BLU_HUE_HI && data_in.side.sat_over_30) begin
			cls = phcc_pkg::CLS_BLUE;
		end else begin
			cls = phcc_pkg::CLS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (adv) begin
			valid_s12 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s12  <= cls;
			gray_s12 <= {v, v, 1'b0, v};
			hue_s12  <= hue;
			sat_s12  <= sat;
			v_s12    <= v;
		end
	end

	assign res.valid              = valid_s12;
	assign res.color_class        = cls_s12;
	assign res.gray_pixel         = gray_s12;
	assign res.hue_degrees        = hue_s12;
	assign res.saturation_percent = sat_s12;
	assign res.value_level        = v_s12;

	`PHCC_ASSERT_ALWAYS(a_hue_range, !valid_s12 || hue_s12 < phcc_pkg::HUE_LIMIT)
	`PHCC_ASSERT_ALWAYS(a_sat_range, !valid_s12 || sat_s12 <= phcc_pkg::SAT_LIMIT)
	`PHCC_ASSERT_ALWAYS(a_white_bright, !valid_s12 || cls_s12 != phcc_pkg::CLS_WHITE || v_s12 > phcc_pkg::WHITE_MIN)
	`PHCC_ASSERT_NEXT(a_load_valid, adv && valid_in, valid_s12)

endmodule

>>> rtl/pixel_hsv_color_classifier.sv
// Depth: 13 register stages lie between a pixel transfer on pix and its result offered on res.
// Throughput: one pixel per cycle while res takes its results; the nine-stage restoring divider that
// produces one hue quotient bit per stage sets the depth, not the rate.
// A stall on res freezes every stage at once, so nothing is lost or repeated.
// Reset: arst_n clears all stage valid bits asynchronously and holds pix.ready
// low while asserted; data is not reset.
`timescale 1ns / 1ps

module pixel_hsv_color_classifier (
	input  logic          clk,
	input  logic          arst_n,
	phcc_pixel_if.sink    pix,
	phcc_result_if.source res
);

	// The whole pipeline moves together. It moves whenever the output
	// register is empty or its result is being transferred this cycle,
	// so a new pixel can be taken in the same cycle a result leaves.
	logic adv;

	assign adv       = !res.valid || res.ready;
	// No pixel is taken while reset holds the stage valid bits clear.
	assign pix.ready = adv && arst_n;

	// div_valid/div_data[0] come out of the front end; entry k+1 is the
	// output of divider step k. The last entry feeds the classifier.
	logic           div_valid [0:phcc_pkg::HQ_W];
	phcc_pkg::div_t div_data  [0:phcc_pkg::HQ_W];

	// Stages 1 to 3: unpack, max/min and mean, then the sector unit scaled
	// into a hue dividend (with the full-turn wrap for negative units) and
	// the saturation dividend 100*d over max.
	phcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pix       (pix),
		.valid_out (div_valid[0]),
		.data_out  (div_data[0])
	);

	// Stages 4 to 12: hue quotient bits from the top down. The saturation
	// quotient needs fewer bits, so its steps share the last stages with
	// the same shift amounts and its value is ready at the same point.
	genvar k;
	generate
		for (k = 0; k < phcc_pkg::HQ_W; k++) begin : g_div
			phcc_div_stage #(
				.SHIFT  (phcc_pkg::HQ_W - 1 - k),
				.SAT_EN (k >= phcc_pkg::SAT_FIRST)
			) u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.valid_in (div_valid[k]),
				.data_in  (div_data[k]),
				.valid_s1 (div_valid[k+1]),
				.data_s1  (div_data[k+1])
			);
		end
	endgenerate

	// Stage 13: zero-spread fixups, gray replication and the ordered
	// class tests, registered into the output channel.
	phcc_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (div_valid[phcc_pkg::HQ_W]),
		.data_in  (div_data[phcc_pkg::HQ_W]),
		.res      (res)
	);

endmodule
